### design/bcpt_pkg.sv
`timescale 1ns / 1ps

package bcpt_pkg;

  // Blind modes
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_OPENING  = 2'd1,
    MODE_CLOSING  = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POS_LOAD,
    ST_DIV,
    ST_TILT_LOAD,
    ST_APPLY
  } state_t;

  // Event kinds
  localparam logic [1:0] OP_STATUS = 2'd0;
  localparam logic [1:0] OP_USER   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Radio status codes
  localparam logic [3:0] ST_TOP         = 4'd0;
  localparam logic [3:0] ST_BOTTOM      = 4'd1;
  localparam logic [3:0] ST_TOP_TILT    = 4'd2;
  localparam logic [3:0] ST_BOTTOM_TILT = 4'd3;
  localparam logic [3:0] ST_TILT        = 4'd4;
  localparam logic [3:0] ST_MOVING_UP   = 4'd5;
  localparam logic [3:0] ST_START_UP    = 4'd6;
  localparam logic [3:0] ST_MOVING_DOWN = 4'd7;
  localparam logic [3:0] ST_START_DOWN  = 4'd8;
  localparam logic [3:0] ST_STOP_FIRST  = 4'd9;
  localparam logic [3:0] ST_STOP_LAST   = 4'd13;

  // User command codes
  localparam logic [3:0] CMD_UP   = 4'd0;
  localparam logic [3:0] CMD_DOWN = 4'd1;
  localparam logic [3:0] CMD_STOP = 4'd2;
  localparam logic [3:0] CMD_TILT = 4'd3;

  // Register indexes
  localparam logic [2:0] REG_OPEN_TRAVEL  = 3'd0;
  localparam logic [2:0] REG_CLOSE_TRAVEL = 3'd1;
  localparam logic [2:0] REG_TILT_SWEEP   = 3'd2;
  localparam logic [2:0] REG_MOVE_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_STOP_COOL    = 3'd4;

  localparam logic [15:0] Q_ONE = 16'hFFFF;

  // Apply a saturated quotient to a base value in the direction of travel
  function automatic logic [15:0] sat_move(input logic [15:0] base, input logic [15:0] q,
                                           input logic sat, input logic up);
    logic [15:0] res;
    if (up) begin
      if (sat || q >= (Q_ONE - base)) res = Q_ONE;
      else res = base + q;
    end else begin
      if (sat || q >= base) res = 16'd0;
      else res = base - q;
    end
    return res;
  endfunction

endpackage

### design/blind_cover_position_tracker_core.sv
`timescale 1ns / 1ps

// Blind cover position tracker.
// Input channel (in_valid / in_stall) carries one event: opcode, event_code
// and now_ms. Each event yields exactly one result on the output channel
// (out_valid / out_stall): mode, position_now, tilt_now and the two tracking
// flags. Configuration is written through cfg_valid / cfg_ready with a
// register index and data; cfg_ready is always high.
// The shared restoring divider runs 16 steps for the position and 16 steps
// for the tilt, each only when that division is needed, besides a multiply
// step, two load steps and an apply step.
// One event is processed at a time; in_stall is high until its result enters
// the output register, so no new event is taken before then.
// The result sits in an output register; a new event may be taken while it
// waits, but the next result is held back until the previous one transfers.
// A stalled result holds its value.
// Reset puts the blind idle at position 0, tilt 0, and loads the register
// defaults (timeout 120000 ms, cooldown 3000 ms, other registers 0).
module blind_cover_position_tracker_core
  import bcpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  event_code,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  mode,
  output logic [15:0] position_now,
  output logic [15:0] tilt_now,
  output logic        position_tracked,
  output logic        tilt_tracked,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  state_t state, state_next;

  logic [19:0] open_travel_ms, close_travel_ms, move_timeout_ms;
  logic [15:0] tilt_sweep_ms, stop_cooldown_ms;

  mode_t       mode_reg;
  logic [15:0] base_position, base_tilt;
  logic [31:0] mark_time;

  logic [1:0]  op_q;
  logic [3:0]  code_q;
  logic [31:0] now_q, elapsed;
  logic [47:0] scaled;
  logic [31:0] dead;
  logic [47:0] rem, dsh;
  logic [15:0] quo;
  logic        sat, div_tilt;
  logic [3:0]  cnt;
  logic [15:0] p_res, t_res;

  logic        moving, opening, pos_go, tilt_go;
  logic [19:0] dur, net;
  logic [15:0] head;
  logic [47:0] pos_num;
  logic [47:0] load_num, load_den;
  logic        div_ge, div_done;
  logic [15:0] div_res;
  logic        out_free;

  mode_t       nm;
  logic [15:0] np, nt;
  logic        chg;
  logic        rt, up_s, down_s, stop_s, up_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // Per-direction operands
  assign moving  = (mode_reg == MODE_OPENING) || (mode_reg == MODE_CLOSING);
  assign opening = (mode_reg == MODE_OPENING);
  assign dur     = opening ? open_travel_ms : close_travel_ms;
  assign net     = (dur > {4'd0, tilt_sweep_ms}) ? dur - {4'd0, tilt_sweep_ms} : 20'd1;
  assign head    = opening ? (Q_ONE - base_tilt) : base_tilt;
  assign pos_num = scaled - {16'd0, dead};
  assign pos_go  = moving && (dur != 20'd0) && (scaled >= {16'd0, dead});
  assign tilt_go = moving && (tilt_sweep_ms != 16'd0);

  // Divider operands for the current load step
  always_comb begin
    if (state == ST_TILT_LOAD) begin
      load_num = scaled;
      load_den = {32'd0, tilt_sweep_ms};
    end else begin
      load_num = pos_num;
      load_den = {28'd0, net};
    end
  end

  assign div_ge   = (rem >= dsh);
  assign div_done = (cnt == 4'd15);
  assign div_res  = sat_move(div_tilt ? base_tilt : base_position,
                             {quo[14:0], div_ge}, sat, opening);

  // Mode transitions
  always_comb begin
    rt     = (code_q == ST_TOP_TILT) || (code_q == ST_BOTTOM_TILT) || (code_q == ST_TILT);
    up_s   = (code_q == ST_MOVING_UP) || (code_q == ST_START_UP);
    down_s = (code_q == ST_MOVING_DOWN) || (code_q == ST_START_DOWN);
    stop_s = (code_q >= ST_STOP_FIRST) && (code_q <= ST_STOP_LAST);
    up_c   = (code_q == CMD_UP) || (code_q == CMD_TILT);
    nm  = mode_reg;
    np  = p_res;
    nt  = t_res;
    chg = 1'b0;
    if (op_q == OP_STATUS) begin
      if (mode_reg == MODE_STOPPING) begin
        if (code_q == ST_TOP) begin
          nm = MODE_IDLE; np = Q_ONE; nt = rt ? Q_ONE : 16'd0; chg = 1'b1;
        end else if (code_q == ST_BOTTOM) begin
          nm = MODE_IDLE; np = 16'd0; nt = rt ? Q_ONE : 16'd0; chg = 1'b1;
        end
      end else if (code_q == ST_TOP || code_q == ST_TOP_TILT) begin
        nm = MODE_IDLE; np = Q_ONE; nt = rt ? Q_ONE : 16'd0; chg = 1'b1;
      end else if (code_q == ST_BOTTOM || code_q == ST_BOTTOM_TILT) begin
        nm = MODE_IDLE; np = 16'd0; nt = rt ? Q_ONE : 16'd0; chg = 1'b1;
      end else if (mode_reg == MODE_IDLE) begin
        if (code_q == ST_TILT) begin
          nt = Q_ONE; chg = 1'b1;
        end else if (up_s) begin
          nm = MODE_OPENING; chg = 1'b1;
        end else if (down_s) begin
          nm = MODE_CLOSING; chg = 1'b1;
        end
      end else begin
        if (code_q == ST_TILT) begin
          nm = MODE_STOPPING; nt = Q_ONE; chg = 1'b1;
        end else if (stop_s) begin
          nm = MODE_STOPPING; chg = 1'b1;
        end else if (opening && down_s) begin
          nm = MODE_CLOSING; chg = 1'b1;
        end else if (!opening && up_s) begin
          nm = MODE_OPENING; chg = 1'b1;
        end
      end
    end else if (op_q == OP_USER) begin
      if (moving) begin
        if (code_q == CMD_STOP) begin
          nm = MODE_STOPPING; chg = 1'b1;
        end else if (opening && code_q == CMD_DOWN) begin
          nm = MODE_CLOSING; chg = 1'b1;
        end else if (!opening && up_c) begin
          nm = MODE_OPENING; chg = 1'b1;
        end
      end else begin
        if (up_c) begin
          nm = MODE_OPENING; chg = 1'b1;
        end else if (code_q == CMD_DOWN) begin
          nm = MODE_CLOSING; chg = 1'b1;
        end
      end
    end else if (op_q == OP_TICK) begin
      if (moving) begin
        if (elapsed >= {12'd0, move_timeout_ms}) begin
          nm = MODE_IDLE; chg = 1'b1;
        end
      end else if (mode_reg == MODE_STOPPING) begin
        if (elapsed >= {16'd0, stop_cooldown_ms}) begin
          nm = MODE_IDLE; np = base_position; nt = base_tilt; chg = 1'b1;
        end
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL;
      ST_MUL:       state_next = ST_POS_LOAD;
      ST_POS_LOAD:  state_next = pos_go ? ST_DIV : ST_TILT_LOAD;
      ST_DIV: begin
        if (div_done) state_next = div_tilt ? ST_APPLY : ST_TILT_LOAD;
      end
      ST_TILT_LOAD: state_next = tilt_go ? ST_DIV : ST_APPLY;
      ST_APPLY:     if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_travel_ms   <= 20'd0;
      close_travel_ms  <= 20'd0;
      tilt_sweep_ms    <= 16'd0;
      move_timeout_ms  <= 20'd120000;
      stop_cooldown_ms <= 16'd3000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_TRAVEL:  open_travel_ms   <= cfg_data;
        REG_CLOSE_TRAVEL: close_travel_ms  <= cfg_data;
        REG_TILT_SWEEP:   tilt_sweep_ms    <= cfg_data[15:0];
        REG_MOVE_TIMEOUT: move_timeout_ms  <= cfg_data;
        REG_STOP_COOL:    stop_cooldown_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Tracker state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_IDLE;
      base_position <= 16'd0;
      base_tilt     <= 16'd0;
      mark_time     <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_APPLY && out_free) begin
        out_valid <= 1'b1;
        mode      <= nm;
        if (chg) begin
          mode_reg      <= nm;
          base_position <= np;
          base_tilt     <= nt;
          mark_time     <= now_q;
          position_now  <= np;
          if ((nm == MODE_OPENING || nm == MODE_CLOSING) && tilt_sweep_ms == 16'd0)
            tilt_now <= (nm == MODE_OPENING) ? Q_ONE : 16'd0;
          else
            tilt_now <= nt;
        end else begin
          position_now <= p_res;
          tilt_now     <= t_res;
        end
        position_tracked <= (open_travel_ms != 20'd0) && (close_travel_ms != 20'd0);
        tilt_tracked     <= (tilt_sweep_ms != 16'd0);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: capture, multiply, shared divider
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op_q    <= opcode;
        code_q  <= event_code;
        now_q   <= now_ms;
        elapsed <= now_ms - mark_time;
      end
      ST_MUL: begin
        scaled <= {elapsed, 16'd0} - {16'd0, elapsed};
        dead   <= head * tilt_sweep_ms;
      end
      ST_POS_LOAD: begin
        p_res    <= base_position;
        div_tilt <= 1'b0;
        rem      <= load_num;
        dsh      <= load_den << 15;
        sat      <= (load_num >= (load_den << 16));
        quo      <= 16'd0;
        cnt      <= 4'd0;
      end
      ST_TILT_LOAD: begin
        if (!moving) t_res <= base_tilt;
        else t_res <= opening ? Q_ONE : 16'd0;
        div_tilt <= 1'b1;
        rem      <= load_num;
        dsh      <= load_den << 15;
        sat      <= (load_num >= (load_den << 16));
        quo      <= 16'd0;
        cnt      <= 4'd0;
      end
      ST_DIV: begin
        if (div_ge) rem <= rem - dsh;
        dsh <= dsh >> 1;
        quo <= {quo[14:0], div_ge};
        cnt <= cnt + 4'd1;
        if (div_done) begin
          if (div_tilt) t_res <= div_res;
          else p_res <= div_res;
        end
      end
      ST_APPLY: ;
      default: ;
    endcase
  end

endmodule
